[hdl/snts_pkg.sv]
package snts_pkg;

	// field widths
	localparam int ADDR_W      = 25;
	localparam int FADDR_W     = 24;
	localparam int LEN_W       = 8;
	localparam int DONE_W      = 25;
	localparam int OPC_W       = 8;
	localparam int LIMIT_W     = 16;
	localparam int CNT_W       = 8;
	localparam int IN_TDATA_W  = 72;
	localparam int OUT_TDATA_W = 72;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 16;

	// step queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;

	// header bytes of a frame (opcode plus 24-bit address)
	localparam logic [CNT_W-1:0]  HDR_BYTES = 8'd4;
	localparam logic [ADDR_W-1:0] MAX_LEN   = 25'h100_0000;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_READ_OPCODE    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PROGRAM_OPCODE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ERASE_OPCODE   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ENABLE_OPCODE  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_STATUS_OPCODE  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_PROGRAM_LIMIT  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_ERASE_LIMIT    = 3'd6;

	// configuration reset values
	localparam logic [OPC_W-1:0]   RST_READ_OPCODE    = 8'd3;
	localparam logic [OPC_W-1:0]   RST_PROGRAM_OPCODE = 8'd2;
	localparam logic [OPC_W-1:0]   RST_ERASE_OPCODE   = 8'd32;
	localparam logic [OPC_W-1:0]   RST_ENABLE_OPCODE  = 8'd6;
	localparam logic [OPC_W-1:0]   RST_STATUS_OPCODE  = 8'd5;
	localparam logic [LIMIT_W-1:0] RST_PROGRAM_LIMIT  = 16'd1000;
	localparam logic [LIMIT_W-1:0] RST_ERASE_LIMIT    = 16'd30000;

	typedef enum logic [1:0] {
		OP_READ  = 2'd0,
		OP_WRITE = 2'd1,
		OP_ERASE = 2'd2,
		OP_REPLY = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		FK_ENABLE  = 3'd0,
		FK_READ    = 3'd1,
		FK_PROGRAM = 3'd2,
		FK_ERASE   = 3'd3,
		FK_POLL    = 3'd4,
		FK_DONE    = 3'd5
	} frame_kind_t;

	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_READ  = 3'd1,
		PH_PROG  = 3'd2,
		PH_PPOLL = 3'd3,
		PH_ERASE = 3'd4,
		PH_EPOLL = 3'd5
	} phase_t;

	// what the front decided for one accepted item
	typedef enum logic [2:0] {
		ACT_NONE  = 3'd0,
		ACT_READ  = 3'd1,
		ACT_WRITE = 3'd2,
		ACT_ERASE = 3'd3,
		ACT_POLL  = 3'd4,
		ACT_DONE  = 3'd5
	} act_t;

	typedef struct packed {
		logic [OPC_W-1:0]   read_opcode;
		logic [OPC_W-1:0]   program_opcode;
		logic [OPC_W-1:0]   erase_opcode;
		logic [OPC_W-1:0]   enable_opcode;
		logic [OPC_W-1:0]   status_opcode;
		logic [LIMIT_W-1:0] program_poll_limit;
		logic [LIMIT_W-1:0] erase_poll_limit;
	} cfg_t;

	// one queued step: a main frame, optionally preceded by a write-enable frame
	typedef struct packed {
		logic                pre_enable;
		frame_kind_t         kind;
		logic [OPC_W-1:0]    cmd;
		logic [FADDR_W-1:0]  addr;
		logic [LEN_W-1:0]    len;
		logic [DONE_W-1:0]   done;
		logic                ok;
	} step_t;

	// one result frame on the output
	typedef struct packed {
		frame_kind_t         kind;
		logic [OPC_W-1:0]    cmd;
		logic [FADDR_W-1:0]  addr;
		logic [LEN_W-1:0]    len;
		logic [DONE_W-1:0]   done;
		logic                ok;
		logic                last;
	} res_t;

endpackage

[hdl/spi_nor_transfer_sequencer.sv]
// SPI NOR transfer sequencer. Read, write and erase requests and SPI replies
// enter on the s_axis side (tuser selects the operation); command frames leave
// on the m_axis side with tuser giving the frame kind and tlast marking the final
// frame caused by one input transfer. A front stage decides each transfer against
// the request state and pushes at most one step into a four-entry queue; the
// back stage turns a step into one frame, or a write-enable frame followed by a
// program or erase frame, through a registered output. The input takes one
// transfer per cycle while the queue has room, and the output sends one frame per
// cycle while the receiver is ready; a two-frame step leaves the queue only when
// its main frame is loaded. The first frame of a transfer passes through the queue
// and then the output register before it is presented. Configuration is written
// through cfg_we, cfg_index and cfg_data and is expected to change only while no
// request runs and all frames have been taken.
module spi_nor_transfer_sequencer #(
	parameter int CHUNK_BYTES  = 128,
	parameter int PAGE_BYTES   = 256,
	parameter int SECTOR_BYTES = 4096
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// start_address, transfer_length, reply_count, reply_status
	input  logic [snts_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
	// operation
	input  logic [1:0]                           s_axis_tuser,
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// command_byte, frame_address, payload_length, bytes_done, success
	output logic [snts_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
	// frame_kind
	output logic [2:0]                           m_axis_tuser,
	output logic                                 m_axis_tlast,
	input  logic                                 cfg_we,
	input  logic [snts_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [snts_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import snts_pkg::*;

	cfg_t    cfg_q;
	step_t   push_data;
	step_t   pop_data;
	res_t    res;
	logic    push;
	logic    pop;
	logic    q_full;
	logic    q_empty;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.read_opcode        <= RST_READ_OPCODE;
			cfg_q.program_opcode     <= RST_PROGRAM_OPCODE;
			cfg_q.erase_opcode       <= RST_ERASE_OPCODE;
			cfg_q.enable_opcode      <= RST_ENABLE_OPCODE;
			cfg_q.status_opcode      <= RST_STATUS_OPCODE;
			cfg_q.program_poll_limit <= RST_PROGRAM_LIMIT;
			cfg_q.erase_poll_limit   <= RST_ERASE_LIMIT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_READ_OPCODE:    cfg_q.read_opcode        <= cfg_data[OPC_W-1:0];
				CFG_PROGRAM_OPCODE: cfg_q.program_opcode     <= cfg_data[OPC_W-1:0];
				CFG_ERASE_OPCODE:   cfg_q.erase_opcode       <= cfg_data[OPC_W-1:0];
				CFG_ENABLE_OPCODE:  cfg_q.enable_opcode      <= cfg_data[OPC_W-1:0];
				CFG_STATUS_OPCODE:  cfg_q.status_opcode      <= cfg_data[OPC_W-1:0];
				CFG_PROGRAM_LIMIT:  cfg_q.program_poll_limit <= cfg_data[LIMIT_W-1:0];
				CFG_ERASE_LIMIT:    cfg_q.erase_poll_limit   <= cfg_data[LIMIT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// request decisions
	snts_front #(
		.CHUNK_BYTES  (CHUNK_BYTES),
		.PAGE_BYTES   (PAGE_BYTES),
		.SECTOR_BYTES (SECTOR_BYTES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_op     (op_t'(s_axis_tuser)),
		.in_addr   (s_axis_tdata[23:0]),
		.in_len    (s_axis_tdata[48:24]),
		.in_cnt    (s_axis_tdata[56:49]),
		.in_status (s_axis_tdata[64:57]),
		.q_full    (q_full),
		.push      (push),
		.entry     (push_data)
	);

	// step queue
	snts_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (push_data),
		.full    (q_full),
		.pop     (pop),
		.rd_data (pop_data),
		.empty   (q_empty)
	);

	// frame output
	snts_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.enable_opcode (cfg_q.enable_opcode),
		.q_empty       (q_empty),
		.q_data        (pop_data),
		.q_pop         (pop),
		.out_valid     (m_axis_tvalid),
		.out_ready     (m_axis_tready),
		.out_res       (res)
	);

	// output packing
	assign m_axis_tdata = {6'b0, res.ok, res.done, res.len, res.addr, res.cmd};
	assign m_axis_tuser = res.kind;
	assign m_axis_tlast = res.last;

endmodule

[hdl/snts_front.sv]
module snts_front #(
	parameter int CHUNK_BYTES  = 128,
	parameter int PAGE_BYTES   = 256,
	parameter int SECTOR_BYTES = 4096
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  snts_pkg::cfg_t                cfg,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  snts_pkg::op_t                 in_op,
	input  logic [snts_pkg::FADDR_W-1:0]  in_addr,
	input  logic [snts_pkg::ADDR_W-1:0]   in_len,
	input  logic [snts_pkg::CNT_W-1:0]    in_cnt,
	input  logic [snts_pkg::CNT_W-1:0]    in_status,
	input  logic                          q_full,
	output logic                          push,
	output snts_pkg::step_t               entry
);
	import snts_pkg::*;

	localparam int CW = $clog2(CHUNK_BYTES + 1);
	localparam int PB = $clog2(PAGE_BYTES);
	localparam int MW = (CW > PB + 1) ? CW : PB + 1;
	localparam int GW = (CW > CNT_W) ? CW : CNT_W;
	localparam logic [ADDR_W-1:0] CHUNK_A  = ADDR_W'(CHUNK_BYTES);
	localparam logic [CW-1:0]     CHUNK_C  = CW'(CHUNK_BYTES);
	localparam logic [ADDR_W-1:0] SEC_MASK = ~(ADDR_W'(SECTOR_BYTES - 1));
	localparam logic [ADDR_W:0]   SEC_STEP = (ADDR_W + 1)'(SECTOR_BYTES);
	localparam logic [PB:0]       PAGE_P   = (PB + 1)'(PAGE_BYTES);

	phase_t               phase_q, phase_d;
	logic [ADDR_W-1:0]    cur_q, cur_d;
	logic [ADDR_W-1:0]    rem_q, rem_d;
	logic [ADDR_W-1:0]    moved_q, moved_d;
	logic [ADDR_W-1:0]    end_q, end_d;
	logic [CW-1:0]        chunk_q, chunk_d;
	logic [CW-1:0]        cmoved_q, cmoved_d;
	logic [LIMIT_W-1:0]   poll_q, poll_d;

	act_t                 act;
	logic [DONE_W-1:0]    fin_done;
	logic                 fin_ok;

	logic                 take;
	logic                 busy;
	logic [ADDR_W-1:0]    len_sat;
	logic [CNT_W-1:0]     data_raw;
	logic [CW-1:0]        got;
	logic [CW-1:0]        amt;
	logic [ADDR_W-1:0]    amt_a;
	logic [ADDR_W-1:0]    adv_rem, adv_cur, adv_moved;
	logic                 start;
	logic [ADDR_W-1:0]    src_rem, src_cur;
	logic [CW-1:0]        rc, wc;
	logic [PB:0]          room;
	logic [ADDR_W-1:0]    beg, er_end;
	logic [LIMIT_W-1:0]   poll_inc;
	logic [ADDR_W:0]      next_sector;
	logic                 sector_last;

	assign in_ready = !q_full;
	assign take     = in_valid && in_ready;
	assign busy     = in_status[0];

	// oversized lengths saturate to the full 16 MiB
	assign len_sat = in_len[ADDR_W-1] ? MAX_LEN : in_len;

	// data bytes of a reply: count minus header, clipped to the frame chunk
	assign data_raw = (in_cnt > HDR_BYTES) ? in_cnt - HDR_BYTES : '0;
	assign got      = (GW'(data_raw) > GW'(chunk_q)) ? chunk_q : CW'(data_raw);

	// advance of the running counters by the bytes of the finished chunk
	assign amt       = (phase_q == PH_READ) ? got : cmoved_q;
	assign amt_a     = ADDR_W'(amt);
	assign adv_rem   = rem_q - amt_a;
	assign adv_cur   = cur_q + amt_a;
	assign adv_moved = moved_q + amt_a;

	// chunk size of the next frame, from the request or the advanced counters
	assign start   = (phase_q == PH_IDLE);
	assign src_rem = start ? len_sat : adv_rem;
	assign src_cur = start ? {1'b0, in_addr} : adv_cur;
	assign rc      = (src_rem > CHUNK_A) ? CHUNK_C : src_rem[CW-1:0];
	assign room    = PAGE_P - (PB + 1)'(src_cur[PB-1:0]);
	assign wc      = (MW'(room) < MW'(rc)) ? CW'(room) : rc;

	// erase range
	assign beg         = {1'b0, in_addr} & SEC_MASK;
	assign er_end      = {1'b0, in_addr} + len_sat;
	assign next_sector = {1'b0, cur_q} + SEC_STEP;
	assign sector_last = next_sector >= {1'b0, end_q};

	assign poll_inc = poll_q + 16'd1;

	// next state and decision
	always_comb begin
		phase_d  = phase_q;
		cur_d    = cur_q;
		rem_d    = rem_q;
		moved_d  = moved_q;
		end_d    = end_q;
		chunk_d  = chunk_q;
		cmoved_d = cmoved_q;
		poll_d   = poll_q;
		act      = ACT_NONE;
		fin_done = '0;
		fin_ok   = 1'b0;
		if (take) begin
			if (in_op != OP_REPLY) begin
				// new request, ignored while one runs
				if (start) begin
					cur_d    = {1'b0, in_addr};
					rem_d    = len_sat;
					moved_d  = '0;
					cmoved_d = '0;
					poll_d   = '0;
					priority if (in_op == OP_ERASE) begin
						end_d = er_end;
						cur_d = beg;
						if (beg < er_end) begin
							act = ACT_ERASE;
						end else begin
							act    = ACT_DONE;
							fin_ok = 1'b1;
						end
					end else if (len_sat == '0) begin
						act    = ACT_DONE;
						fin_ok = 1'b1;
					end else if (in_op == OP_READ) begin
						act     = ACT_READ;
						chunk_d = rc;
					end else begin
						act     = ACT_WRITE;
						chunk_d = wc;
					end
				end
			end else begin
				unique case (phase_q)
					PH_READ: begin
						if (got == '0) begin
							act      = ACT_DONE;
							fin_done = moved_q;
						end else begin
							moved_d = adv_moved;
							rem_d   = adv_rem;
							cur_d   = adv_cur;
							if (amt_a == rem_q) begin
								act      = ACT_DONE;
								fin_done = adv_moved;
								fin_ok   = 1'b1;
							end else begin
								act     = ACT_READ;
								chunk_d = rc;
							end
						end
					end
					PH_PROG: begin
						cmoved_d = got;
						poll_d   = '0;
						if (cfg.program_poll_limit == '0) begin
							act      = ACT_DONE;
							fin_done = moved_q;
						end else begin
							act = ACT_POLL;
						end
					end
					PH_PPOLL: begin
						poll_d = poll_inc;
						if (!busy) begin
							if (cmoved_q == '0) begin
								act      = ACT_DONE;
								fin_done = moved_q;
							end else begin
								moved_d = adv_moved;
								rem_d   = adv_rem;
								cur_d   = adv_cur;
								if (amt_a == rem_q) begin
									act      = ACT_DONE;
									fin_done = adv_moved;
									fin_ok   = 1'b1;
								end else begin
									act     = ACT_WRITE;
									chunk_d = wc;
								end
							end
						end else if (poll_inc >= cfg.program_poll_limit) begin
							act      = ACT_DONE;
							fin_done = moved_q;
						end else begin
							act = ACT_POLL;
						end
					end
					PH_ERASE: begin
						poll_d = '0;
						if (in_cnt != HDR_BYTES || cfg.erase_poll_limit == '0) begin
							act = ACT_DONE;
						end else begin
							act = ACT_POLL;
						end
					end
					PH_EPOLL: begin
						poll_d = poll_inc;
						if (!busy) begin
							if (sector_last) begin
								act    = ACT_DONE;
								fin_ok = 1'b1;
							end else begin
								cur_d = next_sector[ADDR_W-1:0];
								act   = ACT_ERASE;
							end
						end else if (poll_inc >= cfg.erase_poll_limit) begin
							act = ACT_DONE;
						end else begin
							act = ACT_POLL;
						end
					end
					default: begin
					end
				endcase
			end
		end

		// phase follows the decision
		unique case (act)
			ACT_READ:  phase_d = PH_READ;
			ACT_WRITE: phase_d = PH_PROG;
			ACT_ERASE: phase_d = PH_ERASE;
			ACT_POLL: begin
				phase_d = (phase_q == PH_PROG || phase_q == PH_PPOLL) ? PH_PPOLL : PH_EPOLL;
			end
			ACT_DONE:  phase_d = PH_IDLE;
			default:   phase_d = phase_q;
		endcase
	end

	// queued step for the back
	always_comb begin
		entry = '0;
		push  = (act != ACT_NONE);
		unique case (act)
			ACT_READ: begin
				entry.kind = FK_READ;
				entry.cmd  = cfg.read_opcode;
				entry.addr = cur_d[FADDR_W-1:0];
				entry.len  = LEN_W'(chunk_d);
			end
			ACT_WRITE: begin
				entry.pre_enable = 1'b1;
				entry.kind       = FK_PROGRAM;
				entry.cmd        = cfg.program_opcode;
				entry.addr       = cur_d[FADDR_W-1:0];
				entry.len        = LEN_W'(chunk_d);
			end
			ACT_ERASE: begin
				entry.pre_enable = 1'b1;
				entry.kind       = FK_ERASE;
				entry.cmd        = cfg.erase_opcode;
				entry.addr       = cur_d[FADDR_W-1:0];
			end
			ACT_POLL: begin
				entry.kind = FK_POLL;
				entry.cmd  = cfg.status_opcode;
			end
			ACT_DONE: begin
				entry.kind = FK_DONE;
				entry.done = fin_done;
				entry.ok   = fin_ok;
			end
			default: begin
			end
		endcase
	end

	// request state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			cur_q    <= '0;
			rem_q    <= '0;
			moved_q  <= '0;
			end_q    <= '0;
			chunk_q  <= '0;
			cmoved_q <= '0;
			poll_q   <= '0;
		end else begin
			phase_q  <= phase_d;
			cur_q    <= cur_d;
			rem_q    <= rem_d;
			moved_q  <= moved_d;
			end_q    <= end_d;
			chunk_q  <= chunk_d;
			cmoved_q <= cmoved_d;
			poll_q   <= poll_d;
		end
	end

endmodule

[hdl/snts_queue.sv]
module snts_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  snts_pkg::step_t  wr_data,
	output logic             full,
	input  logic             pop,
	output snts_pkg::step_t  rd_data,
	output logic             empty
);
	import snts_pkg::*;

	step_t               mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QPTR_W:0]     count_q;

	assign full    = (count_q == (QPTR_W + 1)'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) full |-> !push)
		else $error("step queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) empty |-> !pop)
		else $error("step queue read while empty");
	a_fill_level: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("step queue fill level lost a transfer");

endmodule

[hdl/snts_back.sv]
module snts_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [snts_pkg::OPC_W-1:0]  enable_opcode,
	input  logic                        q_empty,
	input  snts_pkg::step_t             q_data,
	output logic                        q_pop,
	output logic                        out_valid,
	input  logic                        out_ready,
	output snts_pkg::res_t              out_res
);
	import snts_pkg::*;

	logic   valid_q;
	logic   en_sent_q;
	res_t   out_q;
	res_t   next_res;
	logic   load;
	logic   have;
	logic   send_enable;

	assign load        = !valid_q || out_ready;
	assign have        = !q_empty;
	assign send_enable = q_data.pre_enable && !en_sent_q;
	assign q_pop       = load && have && !send_enable;
	assign out_valid   = valid_q;
	assign out_res     = out_q;

	// next frame: the write-enable ahead of its step, or the step itself
	always_comb begin
		next_res = '0;
		if (send_enable) begin
			next_res.kind = FK_ENABLE;
			next_res.cmd  = enable_opcode;
		end else begin
			next_res.kind = q_data.kind;
			next_res.cmd  = q_data.cmd;
			next_res.addr = q_data.addr;
			next_res.len  = q_data.len;
			next_res.done = q_data.done;
			next_res.ok   = q_data.ok;
			next_res.last = 1'b1;
		end
	end

	// output register data
	always_ff @(posedge clk) begin
		if (load && have) begin
			out_q <= next_res;
		end
	end

	// output valid and enable tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= 1'b0;
			en_sent_q <= 1'b0;
		end else if (load) begin
			valid_q <= have;
			if (have) begin
				en_sent_q <= send_enable;
			end
		end
	end

	a_enable_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && out_q.kind == FK_ENABLE) |-> !out_q.last)
		else $error("write-enable frame marked as last of step");
	a_enable_step_held: assert property (@(posedge clk) disable iff (!arst_n)
		en_sent_q |-> (!q_empty && q_data.pre_enable))
		else $error("step left the queue before its main frame went out");

endmodule

[tb/spi_nor_transfer_sequencer_tb.sv]
module spi_nor_transfer_sequencer_tb;

	import snts_pkg::*;

	localparam int unsigned CHUNK_BYTES  = 128;
	localparam int unsigned PAGE_BYTES   = 256;
	localparam int unsigned SECTOR_BYTES = 4096;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int SETTLE_CYCLES = 8;
	localparam int LONG_HOLD     = 300;

	// one item on the request and reply link
	typedef struct packed {
		logic               drain;
		op_t                op;
		logic [23:0]        addr;
		logic [24:0]        length;
		logic [CNT_W-1:0]   cnt;
		logic [7:0]         status;
	} link_item_t;

	// running request as the sequencer sees it
	typedef struct {
		phase_t             ph;
		logic [24:0]        cur;
		logic [24:0]        rem;
		logic [24:0]        moved;
		logic [24:0]        end_a;
		logic [7:0]         chunk;
		logic [15:0]        polls;
	} request_state_t;

	logic                   clk;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	// start_address, transfer_length, reply_count, reply_status
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	// operation
	logic [1:0]             s_axis_tuser = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	// command_byte, frame_address, payload_length, bytes_done, success
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	// frame_kind
	logic [2:0]             m_axis_tuser;
	logic                   m_axis_tlast;
	logic                   cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	link_item_t     link_items [$];
	res_t           frames_due [$];
	cfg_t           reg_shadow;
	request_state_t pred_st;
	request_state_t plan_st;
	int             last_len;
	int             send_idle_pct = 0;
	int             recv_idle_pct = 0;
	int             hold_requests = 0;
	int             holds_taken = 0;
	int             hold_left = 0;
	int             mismatch_count = 0;
	int             cycle_count = 0;

	spi_nor_transfer_sequencer #(
		.CHUNK_BYTES  (CHUNK_BYTES),
		.PAGE_BYTES   (PAGE_BYTES),
		.SECTOR_BYTES (SECTOR_BYTES)
	) u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	function automatic request_state_t fresh_state();
		request_state_t s;
		s.ph = PH_IDLE;
		s.cur = '0;
		s.rem = '0;
		s.moved = '0;
		s.end_a = '0;
		s.chunk = '0;
		s.polls = '0;
		return s;
	endfunction

	function automatic res_t make_frame(frame_kind_t kind, logic [7:0] cmd, logic [23:0] adr,
			logic [7:0] len, logic [24:0] done, logic ok);
		res_t f;
		f.kind = kind;
		f.cmd = cmd;
		f.addr = adr;
		f.len = len;
		f.done = done;
		f.ok = ok;
		f.last = 1'b0;
		return f;
	endfunction

	function automatic int unsigned read_chunk(request_state_t s);
		return (s.rem > CHUNK_BYTES) ? CHUNK_BYTES : s.rem;
	endfunction

	// a write chunk stops at the next page boundary
	function automatic int unsigned write_chunk(request_state_t s);
		int unsigned blk, here, there;
		blk = read_chunk(s);
		here = s.cur & ~(PAGE_BYTES - 1);
		there = (s.cur + blk) & ~(PAGE_BYTES - 1);
		if (there != here && there > s.cur)
			blk = there - s.cur;
		return blk;
	endfunction

	// data bytes of a reply: header stripped, clamped to the chunk
	function automatic int unsigned data_bytes(logic [7:0] cnt, int unsigned chunk);
		int unsigned d;
		d = (cnt > HDR_BYTES) ? cnt - HDR_BYTES : 0;
		return (d > chunk) ? chunk : d;
	endfunction

	// frames caused by one link item; updates the request state
	function automatic int advance_sequencer(inout request_state_t st, input cfg_t c,
			input link_item_t it, output res_t f0, output res_t f1);
		res_t        fr [$];
		res_t        tail;
		logic [24:0] len;
		int unsigned got;
		logic        busy;
		len = (it.length > MAX_LEN) ? MAX_LEN : it.length;
		busy = it.status[0];
		if (it.op != OP_REPLY) begin
			if (st.ph == PH_IDLE) begin
				st.cur = {1'b0, it.addr};
				st.rem = len;
				st.moved = '0;
				st.chunk = '0;
				st.polls = '0;
				if (it.op == OP_ERASE) begin
					st.end_a = {1'b0, it.addr} + len;
					st.cur = {1'b0, it.addr} & ~25'(SECTOR_BYTES - 1);
					if (st.cur < st.end_a) begin
						fr.push_back(make_frame(FK_ENABLE, c.enable_opcode, 0, 0, 0, 0));
						fr.push_back(make_frame(FK_ERASE, c.erase_opcode, st.cur[23:0], 0, 0, 0));
						st.ph = PH_ERASE;
					end else begin
						fr.push_back(make_frame(FK_DONE, 0, 0, 0, 0, 1'b1));
					end
				end else if (len == 0) begin
					fr.push_back(make_frame(FK_DONE, 0, 0, 0, 0, 1'b1));
				end else if (it.op == OP_READ) begin
					fr.push_back(make_frame(FK_READ, c.read_opcode, st.cur[23:0],
						8'(read_chunk(st)), 0, 0));
					st.ph = PH_READ;
				end else begin
					fr.push_back(make_frame(FK_ENABLE, c.enable_opcode, 0, 0, 0, 0));
					fr.push_back(make_frame(FK_PROGRAM, c.program_opcode, st.cur[23:0],
						8'(write_chunk(st)), 0, 0));
					st.ph = PH_PROG;
				end
			end
		end else begin
			case (st.ph)
				PH_READ: begin
					got = data_bytes(it.cnt, read_chunk(st));
					if (got == 0) begin
						fr.push_back(make_frame(FK_DONE, 0, 0, 0, st.moved, 1'b0));
						st.ph = PH_IDLE;
					end else begin
						st.moved += got;
						st.rem -= got;
						st.cur += got;
						if (st.rem == 0) begin
							fr.push_back(make_frame(FK_DONE, 0, 0, 0, st.moved, 1'b1));
							st.ph = PH_IDLE;
						end else begin
							fr.push_back(make_frame(FK_READ, c.read_opcode, st.cur[23:0],
								8'(read_chunk(st)), 0, 0));
						end
					end
				end
				PH_PROG: begin
					st.chunk = 8'(data_bytes(it.cnt, write_chunk(st)));
					st.polls = '0;
					if (c.program_poll_limit == 0) begin
						fr.push_back(make_frame(FK_DONE, 0, 0, 0, st.moved, 1'b0));
						st.ph = PH_IDLE;
					end else begin
						fr.push_back(make_frame(FK_POLL, c.status_opcode, 0, 0, 0, 0));
						st.ph = PH_PPOLL;
					end
				end
				PH_PPOLL: begin
					st.polls = st.polls + 16'd1;
					if (!busy) begin
						if (st.chunk == 0) begin
							fr.push_back(make_frame(FK_DONE, 0, 0, 0, st.moved, 1'b0));
							st.ph = PH_IDLE;
						end else begin
							st.moved += st.chunk;
							st.rem -= st.chunk;
							st.cur += st.chunk;
							if (st.rem == 0) begin
								fr.push_back(make_frame(FK_DONE, 0, 0, 0, st.moved, 1'b1));
								st.ph = PH_IDLE;
							end else begin
								fr.push_back(make_frame(FK_ENABLE, c.enable_opcode, 0, 0, 0, 0));
								fr.push_back(make_frame(FK_PROGRAM, c.program_opcode,
									st.cur[23:0], 8'(write_chunk(st)), 0, 0));
								st.ph = PH_PROG;
							end
						end
					end else if (st.polls >= c.program_poll_limit) begin
						fr.push_back(make_frame(FK_DONE, 0, 0, 0, st.moved, 1'b0));
						st.ph = PH_IDLE;
					end else begin
						fr.push_back(make_frame(FK_POLL, c.status_opcode, 0, 0, 0, 0));
					end
				end
				PH_ERASE: begin
					st.polls = '0;
					if (it.cnt != HDR_BYTES || c.erase_poll_limit == 0) begin
						fr.push_back(make_frame(FK_DONE, 0, 0, 0, 0, 1'b0));
						st.ph = PH_IDLE;
					end else begin
						fr.push_back(make_frame(FK_POLL, c.status_opcode, 0, 0, 0, 0));
						st.ph = PH_EPOLL;
					end
				end
				PH_EPOLL: begin
					st.polls = st.polls + 16'd1;
					if (!busy) begin
						if (st.cur + SECTOR_BYTES >= st.end_a) begin
							fr.push_back(make_frame(FK_DONE, 0, 0, 0, 0, 1'b1));
							st.ph = PH_IDLE;
						end else begin
							st.cur += SECTOR_BYTES;
							fr.push_back(make_frame(FK_ENABLE, c.enable_opcode, 0, 0, 0, 0));
							fr.push_back(make_frame(FK_ERASE, c.erase_opcode, st.cur[23:0],
								0, 0, 0));
							st.ph = PH_ERASE;
						end
					end else if (st.polls >= c.erase_poll_limit) begin
						fr.push_back(make_frame(FK_DONE, 0, 0, 0, 0, 1'b0));
						st.ph = PH_IDLE;
					end else begin
						fr.push_back(make_frame(FK_POLL, c.status_opcode, 0, 0, 0, 0));
					end
				end
				default: begin
				end
			endcase
		end
		// mark the final frame of this item
		if (fr.size() > 0) begin
			tail = fr.pop_back();
			tail.last = 1'b1;
			fr.push_back(tail);
		end
		f0 = (fr.size() > 0) ? fr[0] : '0;
		f1 = (fr.size() > 1) ? fr[1] : '0;
		return fr.size();
	endfunction

	// queue one item for the driver, tracking where the request will be
	function automatic int plan_item(op_t op, logic [23:0] adr, logic [24:0] len,
			logic [7:0] cnt, logic [7:0] sts, logic drain = 1'b0);
		link_item_t it;
		res_t       f0, f1;
		int         n;
		it.drain = drain;
		it.op = op;
		it.addr = adr;
		it.length = len;
		it.cnt = cnt;
		it.status = sts;
		n = advance_sequencer(plan_st, reg_shadow, it, f0, f1);
		if (n > 0)
			last_len = (n > 1) ? f1.len : f0.len;
		link_items.push_back(it);
		return n;
	endfunction

	function automatic logic [23:0] rand_addr();
		logic [31:0] a;
		int          r;
		a = $urandom;
		r = $urandom_range(99);
		if (r < 20)
			a[7:0] = 8'h80 + 8'($urandom_range(127));
		else if (r < 30)
			a = 32'hFFFFFF - $urandom_range(600);
		else if (r < 40)
			a[11:0] = '0;
		return a[23:0];
	endfunction

	function automatic logic [24:0] rand_len();
		int r;
		r = $urandom_range(99);
		if (r < 5)
			return '0;
		else if (r < 60)
			return 25'($urandom_range(1, 300));
		else if (r < 85)
			return 25'($urandom_range(301, 9000));
		else if (r < 95)
			return 25'($urandom);
		else
			return ($urandom_range(1) != 0) ? MAX_LEN : 25'h1FF_FFFF;
	endfunction

	function automatic string frame_text(res_t f);
		return $sformatf("kind=%0d cmd=%02h addr=%06h len=%0d done=%0d ok=%0b last=%0b",
			f.kind, f.cmd, f.addr, f.len, f.done, f.ok, f.last);
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_READ_OPCODE:    reg_shadow.read_opcode = val[7:0];
			CFG_PROGRAM_OPCODE: reg_shadow.program_opcode = val[7:0];
			CFG_ERASE_OPCODE:   reg_shadow.erase_opcode = val[7:0];
			CFG_ENABLE_OPCODE:  reg_shadow.enable_opcode = val[7:0];
			CFG_STATUS_OPCODE:  reg_shadow.status_opcode = val[7:0];
			CFG_PROGRAM_LIMIT:  reg_shadow.program_poll_limit = val;
			CFG_ERASE_LIMIT:    reg_shadow.erase_poll_limit = val;
			default: begin
			end
		endcase
	endtask

	task automatic load_regs(input logic [15:0] rd, input logic [15:0] pg, input logic [15:0] er,
			input logic [15:0] en, input logic [15:0] st, input logic [15:0] plim,
			input logic [15:0] elim);
		write_reg(CFG_READ_OPCODE, rd);
		write_reg(CFG_PROGRAM_OPCODE, pg);
		write_reg(CFG_ERASE_OPCODE, er);
		write_reg(CFG_ENABLE_OPCODE, en);
		write_reg(CFG_STATUS_OPCODE, st);
		write_reg(CFG_PROGRAM_LIMIT, plim);
		write_reg(CFG_ERASE_LIMIT, elim);
	endtask

	// wait for all items sent and all frames taken, and for the link to stay quiet
	task automatic drain_all();
		int quiet;
		quiet = 0;
		while (quiet < SETTLE_CYCLES) begin
			@(posedge clk);
			if (link_items.size() != 0 || s_axis_tvalid || frames_due.size() != 0)
				quiet = 0;
			else
				quiet++;
		end
	endtask

	// replies that end whatever request is still open
	task automatic close_open_request();
		while (plan_st.ph != PH_IDLE)
			void'(plan_item(OP_REPLY, rand_addr(), rand_len(), 8'd0, 8'd0));
	endtask

	task automatic run_directed();
		// reply with nothing running, zero lengths, zero-length unaligned erase
		void'(plan_item(OP_REPLY, 24'h0, 25'h0, 8'd132, 8'h00));
		void'(plan_item(OP_READ, 24'h000010, 25'h0, 8'd0, 8'h00));
		void'(plan_item(OP_WRITE, 24'hABCDEF, 25'h0, 8'd0, 8'h00));
		void'(plan_item(OP_ERASE, 24'h001000, 25'h0, 8'd0, 8'h00));
		void'(plan_item(OP_ERASE, 24'h000123, 25'h0, 8'd0, 8'h00));
		void'(plan_item(OP_REPLY, 24'h0, 25'h0, 8'd4, 8'h00));
		void'(plan_item(OP_REPLY, 24'h0, 25'h0, 8'd4, 8'h01));
		void'(plan_item(OP_REPLY, 24'h0, 25'h0, 8'd4, 8'hFE));
		// read across the top of the address space, start while busy, partial and short
		void'(plan_item(OP_READ, 24'hFFFFF0, 25'd200, 8'd0, 8'h00));
		void'(plan_item(OP_WRITE, 24'h000000, 25'd64, 8'd0, 8'h00));
		void'(plan_item(OP_REPLY, 24'h0, 25'h0, 8'd132, 8'h00));
		void'(plan_item(OP_REPLY, 24'h0, 25'h0, 8'd14, 8'h00));
		void'(plan_item(OP_REPLY, 24'h0, 25'h0, 8'd3, 8'h00));
		// write crossing a page, busy poll, then a chunk that moved nothing
		void'(plan_item(OP_WRITE, 24'h0000F0, 25'd300, 8'd0, 8'h00));
		void'(plan_item(OP_REPLY, 24'h0, 25'h0, 8'd20, 8'h00));
		void'(plan_item(OP_REPLY, 24'h0, 25'h0, 8'd0, 8'h01));
		void'(plan_item(OP_REPLY, 24'h0, 25'h0, 8'd0, 8'h00));
		void'(plan_item(OP_REPLY, 24'h0, 25'h0, 8'd0, 8'h00));
		void'(plan_item(OP_REPLY, 24'h0, 25'h0, 8'd0, 8'h00));
		// oversized erase with a bad reply count
		void'(plan_item(OP_ERASE, 24'hFFF800, 25'h1FF_FFFF, 8'd0, 8'h00));
		void'(plan_item(OP_REPLY, 24'h0, 25'h0, 8'd5, 8'h00));
		// full-size read cut short
		void'(plan_item(OP_READ, 24'h000000, MAX_LEN, 8'd0, 8'h00));
		void'(plan_item(OP_REPLY, 24'h0, 25'h0, 8'd132, 8'h00));
		void'(plan_item(OP_REPLY, 24'h0, 25'h0, 8'd0, 8'h00));
		// small write that completes
		void'(plan_item(OP_WRITE, 24'h000000, 25'd5, 8'd0, 8'h00));
		void'(plan_item(OP_REPLY, 24'h0, 25'h0, 8'd9, 8'h00));
		void'(plan_item(OP_REPLY, 24'h0, 25'h0, 8'd0, 8'h00));
	endtask

	// mostly well-formed request/reply sequences with some noise
	task automatic run_random(input int quota, input int drain_at);
		int         useful, roll, budget, cnt;
		logic [7:0] sts;
		op_t        op;
		useful = 0;
		budget = 0;
		while (useful < quota) begin
			roll = $urandom_range(99);
			cnt = $urandom_range(132);
			sts = 8'($urandom);
			op = OP_REPLY;
			if (plan_st.ph == PH_IDLE) begin
				if (roll >= 8) begin
					op = op_t'($urandom_range(2));
					budget = $urandom_range(1, 40);
				end
			end else if (roll < 5) begin
				op = op_t'($urandom_range(2));
			end else if (roll < 10) begin
				// noise reply keeps its random count and status
			end else if (budget == 0) begin
				cnt = 0;
				sts = 8'h00;
			end else begin
				budget--;
				roll = $urandom_range(99);
				case (plan_st.ph)
					PH_READ, PH_PROG: begin
						if (roll < 65)
							cnt = 4 + last_len;
						else if (roll < 80)
							cnt = 4 + $urandom_range(1, last_len);
						else if (roll < 88)
							cnt = $urandom_range(4);
						else
							cnt = $urandom_range(4 + last_len, 132);
					end
					PH_ERASE: begin
						if (roll < 90)
							cnt = 4;
					end
					default: begin
						sts[0] = (roll < 30);
					end
				endcase
			end
			if (plan_item(op, rand_addr(), rand_len(), 8'(cnt), sts, useful == drain_at) > 0)
				useful++;
		end
		close_open_request();
	endtask

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// request and reply driver
	always @(posedge clk) begin : link_driver
		logic fired;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			fired = s_axis_tvalid && s_axis_tready;
			if (fired)
				void'(link_items.pop_front());
			if (!s_axis_tvalid || fired) begin
				if (link_items.size() != 0 && $urandom_range(99) >= send_idle_pct &&
				    !(link_items[0].drain && (fired || frames_due.size() != 0))) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= {7'd0, link_items[0].status, link_items[0].cnt,
						link_items[0].length, link_items[0].addr};
					s_axis_tuser <= link_items[0].op;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// frame receiver with random stalls and one long hold-off
	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (hold_requests != holds_taken) begin
				holds_taken = hold_requests;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// check frames, then predict frames of each accepted link item
	always @(posedge clk) begin : frame_monitor
		res_t       seen, want, f0, f1;
		link_item_t acc;
		int         n;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				seen.kind = frame_kind_t'(m_axis_tuser);
				seen.cmd = m_axis_tdata[7:0];
				seen.addr = m_axis_tdata[31:8];
				seen.len = m_axis_tdata[39:32];
				seen.done = m_axis_tdata[64:40];
				seen.ok = m_axis_tdata[65];
				seen.last = m_axis_tlast;
				if (frames_due.size() == 0) begin
					$display("%0t: unexpected frame: expected none, actual %s", $time,
						frame_text(seen));
					mismatch_count++;
				end else begin
					want = frames_due.pop_front();
					if (seen !== want) begin
						$display("%0t: frame mismatch: expected %s, actual %s", $time,
							frame_text(want), frame_text(seen));
						mismatch_count++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				acc.drain = 1'b0;
				acc.op = op_t'(s_axis_tuser);
				acc.addr = s_axis_tdata[23:0];
				acc.length = s_axis_tdata[48:24];
				acc.cnt = s_axis_tdata[56:49];
				acc.status = s_axis_tdata[64:57];
				n = advance_sequencer(pred_st, reg_shadow, acc, f0, f1);
				if (n > 0)
					frames_due.push_back(f0);
				if (n > 1)
					frames_due.push_back(f1);
			end
		end
	end

	// test sequence
	initial begin
		reg_shadow.read_opcode = RST_READ_OPCODE;
		reg_shadow.program_opcode = RST_PROGRAM_OPCODE;
		reg_shadow.erase_opcode = RST_ERASE_OPCODE;
		reg_shadow.enable_opcode = RST_ENABLE_OPCODE;
		reg_shadow.status_opcode = RST_STATUS_OPCODE;
		reg_shadow.program_poll_limit = RST_PROGRAM_LIMIT;
		reg_shadow.erase_poll_limit = RST_ERASE_LIMIT;
		pred_st = fresh_state();
		plan_st = fresh_state();
		last_len = 1;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset register values, slow receiver
		send_idle_pct = 34;
		recv_idle_pct = 78;
		run_directed();
		run_random(290, -1);
		drain_all();

		// random opcodes, tight poll limits
		load_regs(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
			16'($urandom_range(1, 4)), 16'($urandom_range(1, 4)));
		run_random(320, -1);
		drain_all();

		// slow sender, all-zero opcodes and smallest limits
		send_idle_pct = 78;
		recv_idle_pct = 34;
		load_regs(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'd1, 16'd1);
		run_random(300, -1);
		drain_all();

		// all ones written, largest limits
		load_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		run_random(300, -1);
		drain_all();

		// no idling, poll limits of zero fail at once
		send_idle_pct = 0;
		recv_idle_pct = 0;
		load_regs(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
			16'd0, 16'd0);
		run_random(120, -1);
		drain_all();

		// long receiver hold-off, then a pause until every frame is out
		load_regs(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
			16'($urandom_range(2, 6)), 16'($urandom_range(2, 6)));
		hold_requests++;
		run_random(500, 250);
		drain_all();

		if (mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
